FILE: rtl/lts_pkg.sv
// Package with shared types, codes and defaults for the LRU task slot allocator.
`default_nettype none
package lts_pkg;

  localparam int unsigned SlotCountDef = 16;
  localparam int unsigned StampBitsDef = 32;

  localparam logic OP_USE     = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BUSY  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        operation;
    logic        holds_slot;
    logic [3:0]  slot_index;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [3:0] granted_slot;
    logic       evicted;
    logic [3:0] victim_slot;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic cmp_en;
    logic cmp_free;
  } scan_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/lts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lts_scan.sv
// Shared compare unit that tracks the first free slot and the oldest stamp over a scan.
`default_nettype none
module lts_scan #(
  parameter int unsigned SLOT_COUNT = lts_pkg::SlotCountDef,
  parameter int unsigned STAMP_BITS = lts_pkg::StampBitsDef,
  localparam int unsigned SlotBits  = $clog2(SLOT_COUNT)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lts_pkg::scan_ctl_t    ctl_i,
  input  wire logic [SlotBits-1:0]   cmp_idx_i,
  input  wire logic [STAMP_BITS-1:0] stamp_i,
  output logic                       found_free_o,
  output logic      [SlotBits-1:0]   free_idx_o,
  output logic      [SlotBits-1:0]   oldest_idx_o
);
  import lts_pkg::*;

  logic                  found_q, found_d;
  logic                  first_q, first_d;
  logic [SlotBits-1:0]   free_idx_q, free_idx_d;
  logic [SlotBits-1:0]   old_idx_q, old_idx_d;
  logic [STAMP_BITS-1:0] oldest_q, oldest_d;

  always_comb begin
    found_d    = found_q;
    first_d    = first_q;
    free_idx_d = free_idx_q;
    old_idx_d  = old_idx_q;
    oldest_d   = oldest_q;
    if (ctl_i.clear) begin
      found_d = 1'b0;
      first_d = 1'b1;
    end else if (ctl_i.cmp_en) begin
      if (!found_q && ctl_i.cmp_free) begin
        found_d    = 1'b1;
        free_idx_d = cmp_idx_i;
      end
      if (first_q || (stamp_i < oldest_q)) begin
        oldest_d  = stamp_i;
        old_idx_d = cmp_idx_i;
      end
      first_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      first_q <= 1'b1;
    end else begin
      found_q <= found_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    old_idx_q  <= old_idx_d;
    oldest_q   <= oldest_d;
  end

  assign found_free_o = found_q;
  assign free_idx_o   = free_idx_q;
  assign oldest_idx_o = old_idx_q;

endmodule
`default_nettype wire

FILE: rtl/lru_task_slot_allocator.sv
// Top level of the LRU task slot allocator: sequencer, slot state and response register.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | in_req_i  (lts_pkg::req_t)
//   out     | output    | out_valid_o / out_stall_i | out_rsp_o (lts_pkg::rsp_t)
//
// A release, or a use of a slot the task already holds, skips the scan and goes from idle
// straight to its release or write state, which loads the response register. A use that
// needs a slot first scans the stamp RAM through its single read port, one slot per cycle.
// Reset frees every slot and clears the running slot; the stamp RAM needs no clearing.
// While a request is in work in_stall_o is high; a stalled response holds the sequencer.
`default_nettype none
module lru_task_slot_allocator #(
  parameter int unsigned SLOT_COUNT = lts_pkg::SlotCountDef,
  parameter int unsigned STAMP_BITS = lts_pkg::StampBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire lts_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lts_pkg::rsp_t      out_rsp_o
);
  import lts_pkg::*;

  localparam int unsigned SlotBits = $clog2(SLOT_COUNT);
  localparam logic [SlotBits-1:0] LastSlot = SlotBits'(SLOT_COUNT - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_REL   = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [SlotBits-1:0]   cnt_q, cnt_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [SlotBits-1:0]   rd_idx_q, rd_idx_d;
  logic [SLOT_COUNT-1:0] free_q, free_d;
  logic                  run_vld_q, run_vld_d;
  logic [SlotBits-1:0]   run_slot_q, run_slot_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  rsp_q, rsp_d;
  req_t                  req_q, req_d;
  logic                  hold_q, hold_d;

  logic                  ram_we, ram_re;
  logic [SlotBits-1:0]   ram_waddr;
  logic [STAMP_BITS-1:0] ram_rdata;
  scan_ctl_t             scan_ctl;
  logic                  found_free;
  logic [SlotBits-1:0]   free_idx, oldest_idx;
  logic                  load_out;
  logic                  out_busy;
  logic                  req_in_range, in_in_range;
  logic [SlotBits-1:0]   req_slot, sel_slot;

  assign out_busy     = out_valid_q && out_stall_i;
  assign req_in_range = 32'(req_q.slot_index) < 32'(SLOT_COUNT);
  assign in_in_range  = 32'(in_req_i.slot_index) < 32'(SLOT_COUNT);
  assign req_slot     = SlotBits'(req_q.slot_index);
  assign sel_slot     = hold_q ? req_slot : (found_free ? free_idx : oldest_idx);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = cnt_q;
    free_d     = free_q;
    run_vld_d  = run_vld_q;
    run_slot_d = run_slot_q;
    req_d      = req_q;
    hold_d     = hold_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = sel_slot;
    scan_ctl   = '{clear: 1'b0, cmp_en: rd_vld_q, cmp_free: free_q[rd_idx_q]};
    load_out   = 1'b0;
    rsp_d      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_req_i;
          hold_d = in_req_i.holds_slot && in_in_range;
          if (in_req_i.operation == OP_RELEASE) begin
            state_d = S_REL;
          end else if (in_req_i.holds_slot && in_in_range) begin
            state_d = S_WRITE;
          end else begin
            state_d        = S_SCAN;
            cnt_d          = '0;
            scan_ctl.clear = 1'b1;
          end
        end
      end
      S_SCAN: begin
        ram_re   = 1'b1;
        rd_vld_d = 1'b1;
        rd_idx_d = cnt_q;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LastSlot) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (!out_busy) begin
          ram_we     = 1'b1;
          run_vld_d  = 1'b1;
          run_slot_d = sel_slot;
          if (!hold_q) begin
            free_d[sel_slot] = 1'b0;
          end
          rsp_d.granted_slot = 4'(sel_slot);
          rsp_d.evicted      = !hold_q && !found_free;
          rsp_d.victim_slot  = (!hold_q && !found_free) ? 4'(sel_slot) : 4'd0;
          rsp_d.status       = STATUS_OK;
          load_out           = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_REL: begin
        if (!out_busy) begin
          rsp_d.granted_slot = req_q.slot_index;
          priority if (!req_in_range || free_q[req_slot]) begin
            rsp_d.status = STATUS_EMPTY;
          end else if (run_vld_q && (run_slot_q == req_slot)) begin
            rsp_d.status = STATUS_BUSY;
          end else begin
            rsp_d.status     = STATUS_OK;
            free_d[req_slot] = 1'b1;
          end
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_vld_q    <= 1'b0;
      free_q      <= '1;
      run_vld_q   <= 1'b0;
      run_slot_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      free_q      <= free_d;
      run_vld_q   <= run_vld_d;
      run_slot_q  <= run_slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    rd_idx_q <= rd_idx_d;
    req_q    <= req_d;
    hold_q   <= hold_d;
    if (load_out) begin
      rsp_q <= rsp_d;
    end
  end

  lts_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (STAMP_BITS'(req_q.now)),
    .re_i    (ram_re),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  lts_scan #(
    .SLOT_COUNT (SLOT_COUNT),
    .STAMP_BITS (STAMP_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (scan_ctl),
    .cmp_idx_i    (rd_idx_q),
    .stamp_i      (ram_rdata),
    .found_free_o (found_free),
    .free_idx_o   (free_idx),
    .oldest_idx_o (oldest_idx)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted request did not make the block busy");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && rsp_d.evicted |-> free_q == '0)
    else $error("eviction while a free slot exists");

  a_use_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && (req_q.operation == OP_USE) |=> run_vld_q && (run_slot_q == $past(sel_slot)))
    else $error("used slot did not become the running slot");

endmodule
`default_nettype wire
